[rtl/sorted_priority_queue_defines.svh]
// Assertion macros for the sorted priority queue.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SPQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion violated");

// Next-cycle implication, checked outside reset.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion violated");

`endif

[rtl/spq_pkg.sv]
`timescale 1ns / 1ps

package spq_pkg;

  localparam int DEPTH       = 16;
  localparam int AW          = $clog2(DEPTH);
  localparam int CW          = $clog2(DEPTH + 1);
  localparam int LIMIT_W     = 5;
  localparam int DATA_W      = 32;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(10);

  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic [CW-1:0] eff_limit(input logic [LIMIT_W-1:0] lim);
    if (int'(lim) > DEPTH) begin
      return CW'(DEPTH);
    end
    return CW'(lim);
  endfunction

endpackage

[rtl/spq_ram.sv]
`timescale 1ns / 1ps

module spq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/sorted_priority_queue.sv]
// Enqueue: scan stored entries from the tail, one compare per stored entry at worst, then insert;
//   dequeue reads the head and shifts the rest; rejected or empty transactions go straight to S_RESP.
// Throughput: one transaction at a time, in_stall_o high while busy; the one read port, one write
//   port and one comparator step through the entries one per cycle.
// Reset: entry count cleared, capacity limit 10, storage contents left undefined.
`timescale 1ns / 1ps
`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        req_type_i,
  input  logic signed [31:0]          item_value_i,
  input  logic signed [31:0]          item_priority_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [31:0]          out_value_o,
  output logic [1:0]                  status_o,
  output logic                        is_empty_o,
  output logic                        is_full_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [4:0]                  cfg_capacity_limit_i
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_ENQ_CMP  = 3'd1;
  localparam logic [2:0] S_ENQ_INS  = 3'd2;
  localparam logic [2:0] S_DEQ_HEAD = 3'd3;
  localparam logic [2:0] S_DEQ_MV   = 3'd4;
  localparam logic [2:0] S_RESP     = 3'd5;

  logic [2:0]                   state_q, state_d;
  logic [spq_pkg::CW-1:0]       count_q, count_d;
  logic [spq_pkg::CW-1:0]       pos_q, pos_d;
  logic [spq_pkg::LIMIT_W-1:0]  limit_q;
  logic                         req_q, req_d;
  logic signed [31:0]           val_q, val_d;
  logic signed [31:0]           pri_q, pri_d;
  logic signed [31:0]           res_val_q, res_val_d;
  spq_pkg::status_e             res_st_q, res_st_d;

  logic                         out_valid_q;
  logic signed [31:0]           out_val_q;
  logic [1:0]                   out_st_q;
  logic                         out_empty_q;
  logic                         out_full_q;
  logic                         out_load;

  logic                         we;
  logic [spq_pkg::AW-1:0]       wr_addr;
  logic [spq_pkg::AW-1:0]       rd_addr;
  spq_pkg::entry_t              wr_data;
  spq_pkg::entry_t              rd_data;
  logic                         full_now;

  spq_ram #(
    .WIDTH (spq_pkg::ENTRY_W),
    .DEPTH (spq_pkg::DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign full_now    = count_q >= spq_pkg::eff_limit(limit_q);
  assign in_stall_o  = state_q != S_IDLE;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    pos_d     = pos_q;
    req_d     = req_q;
    val_d     = val_q;
    pri_d     = pri_q;
    res_val_d = res_val_q;
    res_st_d  = res_st_q;
    we        = 1'b0;
    wr_addr   = '0;
    wr_data   = rd_data;
    rd_addr   = '0;
    out_load  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d = req_type_i;
          val_d = item_value_i;
          pri_d = item_priority_i;
          if (req_type_i == spq_pkg::REQ_ENQ) begin
            res_val_d = '0;
            if (full_now) begin
              res_st_d = spq_pkg::ST_FULL;
              state_d  = S_RESP;
            end else begin
              res_st_d = spq_pkg::ST_DONE;
              pos_d    = count_q;
              if (count_q == '0) begin
                state_d = S_ENQ_INS;
              end else begin
                rd_addr = spq_pkg::AW'(count_q - 1'b1);
                state_d = S_ENQ_CMP;
              end
            end
          end else begin
            if (count_q == '0) begin
              res_val_d = '1;
              res_st_d  = spq_pkg::ST_EMPTY;
              state_d   = S_RESP;
            end else begin
              res_st_d = spq_pkg::ST_DONE;
              rd_addr  = '0;
              pos_d    = spq_pkg::CW'(1);
              state_d  = S_DEQ_HEAD;
            end
          end
        end
      end
      S_ENQ_CMP: begin
        if (rd_data.prio >= pri_q) begin
          we      = 1'b1;
          wr_addr = pos_q[spq_pkg::AW-1:0];
          wr_data = rd_data;
          pos_d   = spq_pkg::CW'(pos_q - 1'b1);
          if (pos_q == spq_pkg::CW'(1)) begin
            state_d = S_ENQ_INS;
          end else begin
            rd_addr = spq_pkg::AW'(pos_q - 2'd2);
          end
        end else begin
          state_d = S_ENQ_INS;
        end
      end
      S_ENQ_INS: begin
        we            = 1'b1;
        wr_addr       = pos_q[spq_pkg::AW-1:0];
        wr_data.value = val_q;
        wr_data.prio  = pri_q;
        count_d       = spq_pkg::CW'(count_q + 1'b1);
        state_d       = S_RESP;
      end
      S_DEQ_HEAD: begin
        res_val_d = rd_data.value;
        if (pos_q < count_q) begin
          rd_addr = pos_q[spq_pkg::AW-1:0];
          state_d = S_DEQ_MV;
        end else begin
          count_d = spq_pkg::CW'(count_q - 1'b1);
          state_d = S_RESP;
        end
      end
      S_DEQ_MV: begin
        we      = 1'b1;
        wr_addr = spq_pkg::AW'(pos_q - 1'b1);
        wr_data = rd_data;
        pos_d   = spq_pkg::CW'(pos_q + 1'b1);
        if (spq_pkg::CW'(pos_q + 1'b1) < count_q) begin
          rd_addr = spq_pkg::AW'(pos_q + 1'b1);
        end else begin
          count_d = spq_pkg::CW'(count_q - 1'b1);
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      limit_q     <= spq_pkg::LIMIT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_capacity_limit_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    req_q     <= req_d;
    val_q     <= val_d;
    pri_q     <= pri_d;
    res_val_q <= res_val_d;
    res_st_q  <= res_st_d;
    if (out_load) begin
      out_val_q   <= res_val_q;
      out_st_q    <= res_st_q;
      out_empty_q <= count_q == '0;
      out_full_q  <= full_now;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_val_q;
  assign status_o    = out_st_q;
  assign is_empty_o  = out_empty_q;
  assign is_full_o   = out_full_q;

  `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= spq_pkg::CW'(spq_pkg::DEPTH))
  `SPQ_ASSERT_NEXT(a_insert_grows, state_q == S_ENQ_INS, count_q == spq_pkg::CW'($past(count_q) + 1'b1))
  `SPQ_ASSERT_NOW(a_full_only_enq, state_q == S_RESP && res_st_q == spq_pkg::ST_FULL, req_q == spq_pkg::REQ_ENQ)
  `SPQ_ASSERT_NOW(a_scan_pos, state_q == S_ENQ_CMP, pos_q != '0 && pos_q <= count_q)

endmodule
